### hw/rtl/fbtc_pkg.sv
`timescale 1ns / 1ps

package fbtc_pkg;

   localparam logic [7:0] NL_CHAR           = 8'd10;
   localparam logic [7:0] LINE_LENGTH_RESET = 8'd72;
   localparam logic [7:0] ALPHA_BASE        = 8'd65;  // 'A'
   localparam logic [7:0] DIGIT_BASE        = 8'd22;  // '0' - 26
   localparam logic [4:0] ALPHA_COUNT       = 5'd26;
   localparam int         MAX_RESULTS       = 4;

   // register indexes on the csr port
   localparam logic CSR_DECODE_MODE = 1'b0;
   localparam logic CSR_LINE_LENGTH = 1'b1;

   // 5-bit group to text character: A..Z then 0..5
   function automatic logic [7:0] sym_of(input logic [4:0] v);
      logic [7:0] r;
      if (v < ALPHA_COUNT) begin
         r = 8'({3'b000, v}) + ALPHA_BASE;
      end else begin
         r = 8'({3'b000, v}) + DIGIT_BASE;
      end
      return r;
   endfunction

endpackage

### hw/rtl/five_bit_text_codec.sv
`timescale 1ns / 1ps

// Channel   Ports                          Payload (lowest bit first)
// --------  -----------------------------  ----------------------------------
// request   req_tvalid/tready/tdata/tuser  tdata: data_in[7:0]; tuser: flush
// response  rsp_tvalid/tready/tdata/tlast  tdata: char_out[7:0]; tlast: last
// csr       csr_we/index/wdata             index 0 decode_mode, 1 line_length
//
// Each accepted transaction waits in an input register until the result buffer
// can take all of its results (up to four), which are worked out there. The
// buffer drains one result per cycle while rsp_tready is high. An item gives
// one or two characters, plus a newline now and then, or none at all. The
// first result passes through the input register and then the result buffer
// before it is offered on the response channel (rsp_tvalid, rsp_tdata).
// The next item is taken while the buffer still drains; a stalled response
// side holds the buffer, then the input register, then req_tready.
// Reset is synchronous and clears mode, line length (to 72), codec state and valid flags.

module five_bit_text_codec (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_in[7:0]
   input  logic       req_tuser,   // flush
   // response channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // char_out[7:0]
   output logic       rsp_tlast,
   // configuration
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   // configuration registers
   logic       decode_ff;
   logic [7:0] len_ff;

   // codec state
   logic [7:0] acc_ff,  acc_in;
   logic [2:0] fill_ff, fill_in;
   logic [7:0] line_ff, line_in;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_flush_ff;

   // result buffer
   logic       buf_valid_ff;
   logic [7:0] buf_char_ff [fbtc_pkg::MAX_RESULTS];
   logic [2:0] buf_cnt_ff;
   logic [1:0] buf_idx_ff;

   // results of the item in the input register
   logic [7:0] res_char [fbtc_pkg::MAX_RESULTS];
   logic [2:0] res_cnt;

   // encode working values
   logic [15:0] enc_comb;
   logic [3:0]  enc_total;
   logic [4:0]  enc_group;
   logic [7:0]  enc_sym;
   // decode working values
   logic [4:0]  dec_code;
   logic [12:0] dec_comb;
   logic [3:0]  dec_total;

   logic buf_last;
   logic buf_free;
   logic in_go;

   always_comb begin
      for (int i = 0; i < fbtc_pkg::MAX_RESULTS; i++) begin
         res_char[i] = fbtc_pkg::NL_CHAR;
      end
      res_cnt   = 3'd0;
      acc_in    = acc_ff;
      fill_in   = fill_ff;
      line_in   = line_ff;
      enc_comb  = {acc_ff, in_data_ff};
      enc_total = 4'({1'b0, fill_ff}) + 4'd8;
      enc_group = 5'd0;
      enc_sym   = 8'd0;
      dec_code  = (in_data_ff >= fbtc_pkg::ALPHA_BASE)
                  ? 5'(in_data_ff - fbtc_pkg::ALPHA_BASE)
                  : 5'(in_data_ff - fbtc_pkg::DIGIT_BASE);
      dec_comb  = {acc_ff, dec_code};
      dec_total = 4'({1'b0, fill_ff}) + 4'd5;

      if (!decode_ff) begin
         if (in_flush_ff) begin
            // pad the partial group with zeros, then close the line
            if (fill_ff != 3'd0 && fill_ff < 3'd5) begin
               enc_group   = 5'({5'b00000, acc_ff} << (3'd5 - fill_ff));
               res_char[0] = fbtc_pkg::sym_of(enc_group);
               res_char[1] = fbtc_pkg::NL_CHAR;
               res_cnt     = 3'd2;
            end
            acc_in  = 8'd0;
            fill_in = 3'd0;
            line_in = 8'd0;
         end else begin
            // peel off whole 5-bit groups, most significant first
            for (int k = 0; k < 3; k++) begin
               if (enc_total >= 4'd5 && res_cnt <= 3'd2) begin
                  enc_group = 5'(enc_comb >> (enc_total - 4'd5));
                  enc_sym   = fbtc_pkg::sym_of(enc_group);
                  if (line_in >= len_ff) begin
                     res_char[res_cnt[1:0]] = fbtc_pkg::NL_CHAR;
                     res_cnt = res_cnt + 3'd1;
                     line_in = 8'd0;
                  end
                  res_char[res_cnt[1:0]] = enc_sym;
                  res_cnt   = res_cnt + 3'd1;
                  line_in   = line_in + 8'd1;
                  enc_total = enc_total - 4'd5;
               end
            end
            if (enc_total > 4'd7) begin
               enc_total = 4'd7;
            end
            fill_in = enc_total[2:0];
            acc_in  = 8'(enc_comb & ((16'd1 << enc_total) - 16'd1));
         end
      end else begin
         if (in_flush_ff) begin
            // drop trailing partial bits
            acc_in  = 8'd0;
            fill_in = 3'd0;
            line_in = 8'd0;
         end else if (in_data_ff != fbtc_pkg::NL_CHAR) begin
            if (dec_total >= 4'd8) begin
               res_char[0] = 8'(dec_comb >> (dec_total - 4'd8));
               res_cnt     = 3'd1;
               dec_total   = dec_total - 4'd8;
            end
            fill_in = dec_total[2:0];
            acc_in  = 8'(dec_comb & ((13'd1 << dec_total[2:0]) - 13'd1));
         end
      end
   end

   // buffer handshake
   assign buf_last   = ((3'({1'b0, buf_idx_ff}) + 3'd1) == buf_cnt_ff);
   assign buf_free   = !buf_valid_ff || (rsp_tready && buf_last);
   // items with no result leave the input register without the buffer
   assign in_go      = in_valid_ff && (res_cnt == 3'd0 || buf_free);
   assign req_tready = !in_valid_ff || in_go;

   assign rsp_tvalid = buf_valid_ff;
   assign rsp_tdata  = buf_char_ff[buf_idx_ff];
   assign rsp_tlast  = buf_last;

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         decode_ff    <= 1'b0;
         len_ff       <= fbtc_pkg::LINE_LENGTH_RESET;
         acc_ff       <= 8'd0;
         fill_ff      <= 3'd0;
         line_ff      <= 8'd0;
         in_valid_ff  <= 1'b0;
         buf_valid_ff <= 1'b0;
         buf_cnt_ff   <= 3'd0;
         buf_idx_ff   <= 2'd0;
      end else begin
         // advance the codec state as each item leaves the input register
         if (in_go) begin
            acc_ff  <= acc_in;
            fill_ff <= fill_in;
            line_ff <= line_in;
         end

         // the user must write only while idle, which the block does not enforce; a mode write restarts the state
         if (csr_we) begin
            unique case (csr_index)
               fbtc_pkg::CSR_DECODE_MODE: begin
                  decode_ff <= csr_wdata[0];
                  acc_ff    <= 8'd0;
                  fill_ff   <= 3'd0;
                  line_ff   <= 8'd0;
               end
               fbtc_pkg::CSR_LINE_LENGTH: begin
                  len_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end

         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end

         // load a fresh set of results, else step through the current one
         if (in_go && res_cnt != 3'd0) begin
            buf_valid_ff <= 1'b1;
            buf_cnt_ff   <= res_cnt;
            buf_idx_ff   <= 2'd0;
         end else if (buf_valid_ff && rsp_tready) begin
            if (buf_last) begin
               buf_valid_ff <= 1'b0;
            end else begin
               buf_idx_ff <= buf_idx_ff + 2'd1;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff  <= req_tdata;
         in_flush_ff <= req_tuser;
      end
      if (in_go && res_cnt != 3'd0) begin
         for (int i = 0; i < fbtc_pkg::MAX_RESULTS; i++) begin
            buf_char_ff[i] <= res_char[i];
         end
      end
   end

endmodule
